>>> rtl/alpha_blend_rgba8_over_core_defines.svh
// assertion macros used by the checker file
`ifndef ALPHA_BLEND_RGBA8_OVER_CORE_DEFINES_SVH
`define ALPHA_BLEND_RGBA8_OVER_CORE_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define ABO_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error(msg);

// clocked assertion that also watches reset itself
`define ABO_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/abo_pkg.sv
package abo_pkg;

    // register stages from input beat to output register
    localparam int NumStages = 4;

    localparam logic [7:0]  HalfLo    = 8'd126;
    localparam logic [7:0]  HalfHi    = 8'd129;
    localparam logic [7:0]  ChanMax   = 8'd255;
    // (2x + 255) / 510 equals (x + 127) / 255 for integer x
    localparam logic [15:0] RoundBias = 16'd127;

    typedef struct packed {
        logic [NumStages-1:0] load;
    } stage_ctl_t;

endpackage

>>> rtl/abo_ctrl.sv
module abo_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_last,
    output abo_pkg::stage_ctl_t ctl
);

    logic [abo_pkg::NumStages-1:0] valid_reg;
    logic [abo_pkg::NumStages-1:0] valid_next;
    logic [abo_pkg::NumStages-1:0] last_reg;
    logic [abo_pkg::NumStages-1:0] go;

    // a stage may load when it is empty or its content moves on
    always_comb begin
        go[abo_pkg::NumStages-1] = !valid_reg[abo_pkg::NumStages-1] || m_ready;
        for (int i = abo_pkg::NumStages - 2; i >= 0; i--) begin
            go[i] = !valid_reg[i] || go[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (go[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < abo_pkg::NumStages; i++) begin
            if (go[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // last flag travels alongside the pixel data
    always_ff @(posedge aclk) begin
        if (go[0]) begin
            last_reg[0] <= s_last;
        end
        for (int i = 1; i < abo_pkg::NumStages; i++) begin
            if (go[i]) begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    assign ctl.load = go;
    assign s_ready  = go[0];
    assign m_valid  = valid_reg[abo_pkg::NumStages-1];
    assign m_last   = last_reg[abo_pkg::NumStages-1];

endmodule

>>> rtl/abo_chan.sv
module abo_chan (
    input  logic                aclk,
    input  abo_pkg::stage_ctl_t ctl,
    input  logic [7:0]          src,
    input  logic [7:0]          dst,
    input  logic [7:0]          alpha,
    output logic [7:0]          blended
);

    // stage 0: products
    logic [15:0] p_src_reg;
    logic [15:0] p_dst_reg;
    logic        half0_reg;
    logic [7:0]  hsum0_reg;
    // stage 1: weighted sum plus rounding bias
    logic [15:0] y1_reg;
    logic        half1_reg;
    logic [7:0]  hsum1_reg;
    // stage 2: quotient estimate by reciprocal of 255
    logic [15:0] y2_reg;
    logic [7:0]  qe2_reg;
    logic        half2_reg;
    logic [7:0]  hsum2_reg;
    // stage 3: output
    logic [7:0]  out_reg;
    logic [7:0]  out_next;

    logic [7:0]  inv_alpha;
    logic [8:0]  hsum_wide;
    logic [23:0] y_times_257;
    logic [15:0] rem;

    assign inv_alpha = abo_pkg::ChanMax - alpha;
    assign hsum_wide = {1'b0, src} + {1'b0, dst} + 9'd1;

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            p_src_reg <= {8'd0, alpha} * {8'd0, src};
            p_dst_reg <= {8'd0, inv_alpha} * {8'd0, dst};
            half0_reg <= (alpha >= abo_pkg::HalfLo) && (alpha <= abo_pkg::HalfHi);
            hsum0_reg <= hsum_wide[8:1];
        end
    end

    // largest sum is 65025 + 127, still inside 16 bits
    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            y1_reg    <= p_src_reg + p_dst_reg + abo_pkg::RoundBias;
            half1_reg <= half0_reg;
            hsum1_reg <= hsum0_reg;
        end
    end

    // y * 257 / 65536 undershoots y / 255 by less than one
    assign y_times_257 = {y1_reg, 8'd0} + {8'd0, y1_reg};

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            y2_reg    <= y1_reg;
            qe2_reg   <= y_times_257[23:16];
            half2_reg <= half1_reg;
            hsum2_reg <= hsum1_reg;
        end
    end

    // remainder below 510, one correction step
    assign rem = y2_reg - {qe2_reg, 8'd0} + {8'd0, qe2_reg};

    always_comb begin
        if (half2_reg) begin
            out_next = hsum2_reg;
        end else if (rem >= {8'd0, abo_pkg::ChanMax}) begin
            out_next = qe2_reg + 8'd1;
        end else begin
            out_next = qe2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            out_reg <= out_next;
        end
    end

    assign blended = out_reg;

endmodule

>>> rtl/alpha_blend_rgba8_over_core.sv
// source-over blend of an rgba8 source pixel onto an rgb8 destination pixel
//
// input channel (s_): one beat carries the source colour and alpha, the
// destination colour and a last flag marking the end of a span
// output channel (m_): one beat per input beat, same order, carrying the
// blended colour and the copied last flag
// alpha 0 returns the destination, alpha 126 to 129 averages source and
// destination rounding up, any other alpha blends at alpha/255 rounded
// to nearest; alpha 255 returns the source exactly
//
// throughput: one beat per clock while the receiver keeps m_ready high,
// held by a four-stage pipeline per channel (multiply, sum, reciprocal
// estimate, remainder correction); a beat passes each stage register in
// that order before it is on the m_ side
//
// reset (aresetn low, synchronous) empties the pipeline: m_valid drops and
// s_ready rises on the next cycle; no other state is held
// when the receiver stalls, a full stage holds its beat unless a stage after
// it is free; s_ready stays high while any stage has a free slot, so bubbles
// are squeezed out before the input side is held off
module alpha_blend_rgba8_over_core (
    input  logic       aclk,
    input  logic       aresetn,
    // pixel input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_src_red,
    input  logic [7:0] s_src_green,
    input  logic [7:0] s_src_blue,
    input  logic [7:0] s_src_alpha,
    input  logic [7:0] s_dst_red,
    input  logic [7:0] s_dst_green,
    input  logic [7:0] s_dst_blue,
    input  logic       s_last_pixel,
    // blended output
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_red,
    output logic [7:0] m_out_green,
    output logic [7:0] m_out_blue,
    output logic       m_out_last
);

    // per-stage load enables shared by the three colour lanes
    abo_pkg::stage_ctl_t ctl;

    // valid bits, ready chain and last flag
    abo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last_pixel),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_out_last),
        .ctl     (ctl)
    );

    // one arithmetic lane per colour channel, alpha shared
    abo_chan u_chan_red (
        .aclk    (aclk),
        .ctl     (ctl),
        .src     (s_src_red),
        .dst     (s_dst_red),
        .alpha   (s_src_alpha),
        .blended (m_out_red)
    );

    abo_chan u_chan_green (
        .aclk    (aclk),
        .ctl     (ctl),
        .src     (s_src_green),
        .dst     (s_dst_green),
        .alpha   (s_src_alpha),
        .blended (m_out_green)
    );

    abo_chan u_chan_blue (
        .aclk    (aclk),
        .ctl     (ctl),
        .src     (s_src_blue),
        .dst     (s_dst_blue),
        .alpha   (s_src_alpha),
        .blended (m_out_blue)
    );

endmodule

>>> rtl/abo_checker.sv
`include "alpha_blend_rgba8_over_core_defines.svh"

module abo_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_red,
    input logic [7:0] m_out_green,
    input logic [7:0] m_out_blue,
    input logic       m_out_last
);

    // pipeline is empty straight after reset
    `ABO_ASSERT(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")

    // free output slot means the input side can never be held off
    `ABO_ASSERT_RST(a_ready_when_room, aclk, aresetn,
        (!m_valid || m_ready) |-> s_ready,
        "input stalled with room in pipeline")

    // with the receiver ready, a taken beat moves through each pipeline stage in turn and reaches the output
    `ABO_ASSERT_RST(a_latency, aclk, aresetn,
        ($past(s_valid && s_ready, 4) && $past(m_ready, 3) && $past(m_ready, 2)
            && $past(m_ready, 1) && $past(aresetn, 3) && $past(aresetn, 2)
            && $past(aresetn, 1)) |-> m_valid,
        "beat did not arrive in time")

    // stalled output beat holds
    `ABO_ASSERT_RST(a_out_hold, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_red)
            && $stable(m_out_green) && $stable(m_out_blue) && $stable(m_out_last)),
        "stalled output beat changed")

endmodule

bind alpha_blend_rgba8_over_core abo_checker u_abo_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_red   (m_out_red),
    .m_out_green (m_out_green),
    .m_out_blue  (m_out_blue),
    .m_out_last  (m_out_last)
);
